FILE: hdl/assert_macros.svh
// Assertion macros shared by the thermal plant RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// When pre holds, post holds at the next clock edge.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/tpm_pkg.sv
// Types and constants of the thermal plant model.
// Used by tpm_mul, thermal_plant_model_step, plant_checker and testbench; no dependencies.
package tpm_pkg;

	localparam int MCW  = 48;
	localparam int MPW  = 64;
	localparam int DIG  = 8;
	localparam int NDIG = MPW / DIG;
	localparam int PW   = 112;
	localparam int SW   = 96;
	localparam int TDW  = 31;

	localparam longint HALF_PI_Q30 = 64'd1686629713;
	localparam longint ONE_Q30     = 64'd1073741824;
	localparam logic [45:0] INV2PI_K = (46'(683565275) << 16) | 46'(37777);
	localparam longint SERIES_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

	typedef enum logic [2:0] {
		REG_MODE,
		REG_COEF_A,
		REG_COEF_B,
		REG_COEF_C,
		REG_COEF_D,
		REG_INIT_TEMP,
		REG_INIT_OLDER,
		REG_INIT_CONTROL
	} cfg_reg_t;

	typedef struct packed {
		logic                  start;
		logic signed [MCW-1:0] mcand;
		logic signed [MPW-1:0] mpl;
	} mul_req_t;

endpackage

FILE: hdl/tpm_mul.sv
// Digit-serial signed multiplier, one 8-bit digit of the multiplier per cycle.
// Depends on tpm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tpm_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tpm_pkg::mul_req_t                req,
	output logic                             done,
	output logic signed [tpm_pkg::PW-1:0]    product
);
	import tpm_pkg::*;

	localparam int ACW = MCW + DIG + 1;
	localparam int CW  = $clog2(NDIG);
	localparam logic [CW-1:0] CNT_LAST = CW'(NDIG - 1);

	logic signed [MCW-1:0]     mcand_q;
	logic signed [ACW-1:0]     acc_q;
	logic [MPW-1:0]            mpl_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic signed [DIG:0]       digit;
	logic signed [ACW-1:0]     partial;
	logic signed [ACW-1:0]     sum_w;
	logic signed [ACW+MPW-1:0] shifted;

	always_comb begin
		if (cnt_q == CNT_LAST) begin
			digit = {mpl_q[DIG-1], mpl_q[DIG-1:0]};
		end else begin
			digit = {1'b0, mpl_q[DIG-1:0]};
		end
		partial = ACW'(mcand_q) * ACW'(digit);
		sum_w   = acc_q + partial;
		shifted = $signed({sum_w, mpl_q}) >>> DIG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= req.mcand;
			acc_q   <= '0;
			mpl_q   <= req.mpl;
		end else if (busy_q) begin
			{acc_q, mpl_q} <= shifted;
		end
	end

	assign done    = done_q;
	assign product = $signed(PW'({acc_q, mpl_q}));

	`ASSERT_CLK(a_start_idle, req.start |-> !busy_q, "multiplier started while busy")
	`ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")
	`ASSERT_CLK(a_idle_cnt, !busy_q |-> (cnt_q == '0), "digit count not at zero when idle")

endmodule

FILE: hdl/thermal_plant_model_step.sv
// Thermal plant model step: one command in, one temperature out, signed fixed point.
// Depends on tpm_pkg, tpm_mul and assert_macros.svh.
//
// Each step runs its products one at a time through a digit-serial multiplier.
// A linear step runs two products, a nonlinear step seven products plus the
// sine table lookup, and a restart none. One item is in flight at a time; a
// finished result may wait in the output register while the next item is taken.
`include "assert_macros.svh"
module thermal_plant_model_step #(
	parameter int FRAC_BITS        = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [31:0] control,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] temperature,
	output logic               saturated
);
	import tpm_pkg::*;

	localparam int TAW    = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PSW    = 30 + TAW;
	localparam int PH_LSB = 16 + FRAC_BITS;

	typedef logic [TDW-1:0] sine_tab_t [SINE_TABLE_DEPTH+1];

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		longint    x;
		longint    x2;
		longint    term;
		longint    acc;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x    = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
			x2   = (x * x) >>> 30;
			term = x;
			acc  = x;
			for (int k = 0; k < 8; k++) begin
				term = ((term * x2) >>> 30) / SERIES_DIV[k];
				if (k[0] == 1'b0) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > ONE_Q30) begin
				acc = ONE_Q30;
			end
			t[i] = TDW'(acc);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_A, S_MUL_U, S_MUL_SQ, S_MUL_B, S_MUL_PH, S_POS,
		S_ROM0, S_ROM1, S_MUL_FR, S_MUL_D, S_SAT, S_DONE
	} state_t;

	state_t             state_q;
	logic               mode_q;
	logic signed [31:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic signed [31:0] init_temp_q, init_older_q, init_control_q;
	logic signed [31:0] temp_last_q, temp_before_q, control_last_q;
	logic               cmd_q;
	logic signed [31:0] u_q;
	logic signed [SW-1:0] sum_q;
	logic [MPW-1:0]     sq_q;
	logic [31:0]        ph_q;
	logic [PSW-1:0]     pos_q;
	logic [TDW-1:0]     tab_q, lo_q;
	logic signed [31:0] s_q;
	logic signed [31:0] res_q;
	logic               sat_q;
	logic               mul_pend_q;
	logic               out_valid_q;
	logic signed [31:0] temperature_q;
	logic               saturated_q;

	mul_req_t              mul_req;
	logic                  mul_done;
	logic signed [PW-1:0]  product;
	logic                  is_mul;
	logic signed [SW-1:0]  term_f, term_30;
	logic [TAW-1:0]        idx, rom_addr;
	logic                  rom_en;
	logic [30:0]           r_w;
	logic signed [31:0]    diff_w, v_w;
	logic                  sat_hi, sat_lo;

	tpm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (product)
	);

	always_comb begin
		idx      = pos_q[PSW-1:30];
		r_w      = ph_q[30] ? (31'h4000_0000 - {1'b0, ph_q[29:0]}) : {1'b0, ph_q[29:0]};
		diff_w   = $signed({1'b0, tab_q}) - $signed({1'b0, lo_q});
		v_w      = $signed({1'b0, lo_q}) + 32'(product >>> 30);
		term_f   = SW'(product >>> FRAC_BITS);
		term_30  = SW'(product >>> 30);
		rom_en   = (state_q == S_ROM0) || (state_q == S_ROM1);
		if (state_q == S_ROM0 || idx == TAW'(SINE_TABLE_DEPTH)) begin
			rom_addr = idx;
		end else begin
			rom_addr = idx + 1'b1;
		end
		sat_hi = !sum_q[SW-1] && (|sum_q[SW-2:31]);
		sat_lo = sum_q[SW-1] && !(&sum_q[SW-2:31]);
		is_mul = 1'b1;
		mul_req.mcand = '0;
		mul_req.mpl   = '0;
		unique case (state_q)
			S_MUL_A: begin
				mul_req.mcand = MCW'(coef_a_q);
				mul_req.mpl   = MPW'(temp_last_q);
			end
			S_MUL_U: begin
				mul_req.mcand = mode_q ? MCW'(coef_c_q) : MCW'(coef_b_q);
				mul_req.mpl   = MPW'(u_q);
			end
			S_MUL_SQ: begin
				mul_req.mcand = MCW'(temp_before_q);
				mul_req.mpl   = MPW'(temp_before_q);
			end
			S_MUL_B: begin
				mul_req.mcand = MCW'(coef_b_q);
				mul_req.mpl   = sq_q;
			end
			S_MUL_PH: begin
				mul_req.mcand = $signed(MCW'(INV2PI_K));
				mul_req.mpl   = MPW'(control_last_q);
			end
			S_MUL_FR: begin
				mul_req.mcand = MCW'(diff_w);
				mul_req.mpl   = MPW'(pos_q[29:0]);
			end
			S_MUL_D: begin
				mul_req.mcand = MCW'(coef_d_q);
				mul_req.mpl   = MPW'(s_q);
			end
			default: is_mul = 1'b0;
		endcase
		mul_req.start = is_mul && !mul_pend_q;
	end

	always_ff @(posedge clk) begin
		if (rom_en) begin
			tab_q <= SINE_TAB[rom_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			coef_a_q       <= '0;
			coef_b_q       <= '0;
			coef_c_q       <= '0;
			coef_d_q       <= '0;
			init_temp_q    <= '0;
			init_older_q   <= '0;
			init_control_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:         mode_q         <= cfg_data[0];
				REG_COEF_A:       coef_a_q       <= cfg_data;
				REG_COEF_B:       coef_b_q       <= cfg_data;
				REG_COEF_C:       coef_c_q       <= cfg_data;
				REG_COEF_D:       coef_d_q       <= cfg_data;
				REG_INIT_TEMP:    init_temp_q    <= cfg_data;
				REG_INIT_OLDER:   init_older_q   <= cfg_data;
				REG_INIT_CONTROL: init_control_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mul_pend_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			temperature_q  <= '0;
			saturated_q    <= 1'b0;
			temp_last_q    <= '0;
			temp_before_q  <= '0;
			control_last_q <= '0;
			cmd_q          <= 1'b0;
			u_q            <= '0;
			sum_q          <= '0;
			sq_q           <= '0;
			ph_q           <= '0;
			pos_q          <= '0;
			lo_q           <= '0;
			s_q            <= '0;
			res_q          <= '0;
			sat_q          <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (mul_req.start) begin
				mul_pend_q <= 1'b1;
			end
			if (mul_done) begin
				mul_pend_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						u_q   <= control;
						sum_q <= '0;
						if (command) begin
							temp_last_q    <= init_temp_q;
							temp_before_q  <= init_older_q;
							control_last_q <= init_control_q;
							res_q          <= init_temp_q;
							sat_q          <= 1'b0;
							state_q        <= S_DONE;
						end else begin
							state_q <= S_MUL_A;
						end
					end
				end
				S_MUL_A: begin
					if (mul_done) begin
						sum_q   <= sum_q + term_f;
						state_q <= S_MUL_U;
					end
				end
				S_MUL_U: begin
					if (mul_done) begin
						sum_q   <= sum_q + term_f;
						state_q <= mode_q ? S_MUL_SQ : S_SAT;
					end
				end
				S_MUL_SQ: begin
					if (mul_done) begin
						sq_q    <= MPW'(product >>> FRAC_BITS);
						state_q <= S_MUL_B;
					end
				end
				S_MUL_B: begin
					if (mul_done) begin
						sum_q   <= sum_q - term_f;
						state_q <= S_MUL_PH;
					end
				end
				S_MUL_PH: begin
					if (mul_done) begin
						ph_q    <= product[PH_LSB +: 32];
						state_q <= S_POS;
					end
				end
				S_POS: begin
					pos_q   <= PSW'(r_w) * PSW'(SINE_TABLE_DEPTH);
					state_q <= S_ROM0;
				end
				S_ROM0: begin
					state_q <= S_ROM1;
				end
				S_ROM1: begin
					lo_q    <= tab_q;
					state_q <= S_MUL_FR;
				end
				S_MUL_FR: begin
					if (mul_done) begin
						s_q     <= ph_q[31] ? -v_w : v_w;
						state_q <= S_MUL_D;
					end
				end
				S_MUL_D: begin
					if (mul_done) begin
						sum_q   <= sum_q + term_30;
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					priority if (sat_hi) begin
						res_q <= 32'sh7fff_ffff;
						sat_q <= 1'b1;
					end else if (sat_lo) begin
						res_q <= 32'sh8000_0000;
						sat_q <= 1'b1;
					end else begin
						res_q <= sum_q[31:0];
						sat_q <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						temperature_q <= res_q;
						saturated_q   <= sat_q;
						if (!cmd_q) begin
							temp_before_q  <= temp_last_q;
							temp_last_q    <= res_q;
							control_last_q <= u_q;
						end
						state_q <= S_IDLE;
					end else begin
						out_valid_q <= out_valid_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign temperature = temperature_q;
	assign saturated   = saturated_q;

	`ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	`ASSERT_CLK(a_sat_value, (out_valid && saturated) |-> (temperature == 32'sh7fff_ffff || temperature == 32'sh8000_0000), "saturated flag without clipped value")
	`ASSERT_CLK(a_mul_pend, mul_done |-> mul_pend_q, "product returned without a request")

endmodule

FILE: tb/plant_checker.sv
// Checker for thermal_plant_model_step: snoops the register port and both channels,
// predicts each temperature and compares it with the result transfer. Depends on tpm_pkg.
module plant_checker #(
	parameter int FRAC_BITS        = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               command,
	input  logic signed [31:0] control,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] temperature,
	input  logic               saturated,
	output int                 errors,
	output int                 pending,
	output int                 results,
	output int                 clipped
);
	timeunit 1ns;
	timeprecision 1ps;
	import tpm_pkg::*;

	localparam longint SQ_CLAMP = 64'sd1 << 56;

	typedef struct {
		logic signed [31:0] temp;
		logic               sat;
	} plant_result_t;

	plant_result_t temp_queue[$];
	longint sine_rom [SINE_TABLE_DEPTH+1];

	logic   nonlinear;
	longint gain_a, gain_b, gain_c, gain_d;
	longint start_temp, start_older, start_control;
	longint y_last, y_older, u_last;

	initial begin
		longint x, x2, term, acc;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x = HALF_PI_Q30 * i / SINE_TABLE_DEPTH;
			x2 = (x * x) >>> 30;
			term = x;
			acc = x;
			for (int k = 1; k <= 8; k++) begin
				term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
				if (k % 2 == 1) acc -= term;
				else acc += term;
			end
			if (acc < 0) acc = 0;
			if (acc > ONE_Q30) acc = ONE_Q30;
			sine_rom[i] = acc;
		end
	end

	function automatic longint sine_of(longint u);
		longint q, r, pos, idx, fr, v;
		logic [31:0] ph;
		q = u * 64'sd683565275 + ((u * 64'sd37777) >>> 16);
		ph = q[FRAC_BITS+31:FRAC_BITS];
		r = longint'(ph[29:0]);
		if (ph[30]) r = ONE_Q30 - r;
		pos = r * SINE_TABLE_DEPTH;
		idx = pos >>> 30;
		fr = pos & 64'sh3fffffff;
		if (idx >= SINE_TABLE_DEPTH) v = sine_rom[SINE_TABLE_DEPTH];
		else v = sine_rom[idx] + (((sine_rom[idx+1] - sine_rom[idx]) * fr) >>> 30);
		if (ph[31]) v = -v;
		return v;
	endfunction

	function automatic longint square_of_older();
		logic [63:0] ysq;
		longint sq, sh, sl, mag;
		ysq = y_older * y_older;
		sq = longint'(ysq >> FRAC_BITS);
		sh = sq >>> FRAC_BITS;
		sl = sq & ((64'sd1 << FRAC_BITS) - 1);
		mag = (gain_b < 0) ? -gain_b : gain_b;
		if (sh != 0 && mag > SQ_CLAMP / sh) return (gain_b < 0) ? -SQ_CLAMP : SQ_CLAMP;
		return gain_b * sh + ((gain_b * sl) >>> FRAC_BITS);
	endfunction

	function automatic plant_result_t next_temp(logic cmd, longint u);
		plant_result_t r;
		longint acc;
		if (cmd) begin
			r.temp = start_temp[31:0];
			r.sat = 1'b0;
			y_last = start_temp;
			y_older = start_older;
			u_last = start_control;
			return r;
		end
		acc = (gain_a * y_last) >>> FRAC_BITS;
		if (nonlinear) begin
			acc += (gain_c * u) >>> FRAC_BITS;
			acc += (gain_d * sine_of(u_last)) >>> 30;
			acc -= square_of_older();
		end else begin
			acc += (gain_b * u) >>> FRAC_BITS;
		end
		r.sat = 1'b0;
		if (acc > 64'sd2147483647) begin
			acc = 64'sd2147483647;
			r.sat = 1'b1;
		end else if (acc < -64'sd2147483648) begin
			acc = -64'sd2147483648;
			r.sat = 1'b1;
		end
		r.temp = acc[31:0];
		y_older = y_last;
		y_last = acc;
		u_last = u;
		return r;
	endfunction

	assign pending = temp_queue.size();

	always @(posedge clk or negedge arst_n) begin
		plant_result_t exp_r;
		longint data_s;
		if (!arst_n) begin
			nonlinear <= 1'b0;
			gain_a = 0; gain_b = 0; gain_c = 0; gain_d = 0;
			start_temp = 0; start_older = 0; start_control = 0;
			y_last = 0; y_older = 0; u_last = 0;
			temp_queue.delete();
			errors <= 0;
			results <= 0;
			clipped <= 0;
		end else begin
			if (cfg_we) begin
				data_s = $signed(cfg_data);
				case (cfg_reg_t'(cfg_index))
					REG_MODE:         nonlinear <= cfg_data[0];
					REG_COEF_A:       gain_a = data_s;
					REG_COEF_B:       gain_b = data_s;
					REG_COEF_C:       gain_c = data_s;
					REG_COEF_D:       gain_d = data_s;
					REG_INIT_TEMP:    start_temp = data_s;
					REG_INIT_OLDER:   start_older = data_s;
					REG_INIT_CONTROL: start_control = data_s;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				results <= results + 1;
				if (saturated) clipped <= clipped + 1;
				if (temp_queue.size() == 0) begin
					$error("result transfer with nothing expected: temperature %0d", temperature);
					errors <= errors + 1;
				end else begin
					exp_r = temp_queue.pop_front();
					if (temperature !== exp_r.temp || saturated !== exp_r.sat) begin
						if (temperature !== exp_r.temp)
							$error("temperature: expected %0d, actual %0d", exp_r.temp, temperature);
						if (saturated !== exp_r.sat)
							$error("saturated: expected %0b, actual %0b", exp_r.sat, saturated);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && in_ready)
				temp_queue.push_back(next_temp(command, longint'(control)));
		end
	end
endmodule

FILE: tb/testbench.sv
// Top of the thermal plant regression: clock, reset, register setup and stimulus.
// Depends on tpm_pkg, plant_checker and thermal_plant_model_step.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tpm_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int PHASES     = 12;
	localparam int PER_PHASE  = 128;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               command;
	logic signed [31:0] control;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] temperature;
	logic               saturated;
	int                 errors, pending, results, clipped;
	int                 idle_cycles;
	int                 n_steps, n_restarts, n_settings;
	logic               hold_req;

	thermal_plant_model_step dut (.*);

	plant_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int wait_n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				wait_n = $urandom_range(0, 7);
				if (wait_n > 0) begin
					out_ready <= 1'b0;
					repeat (wait_n) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic transfer(logic cmd, logic [31:0] u);
		int gap;
		gap = $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		control <= u;
		do @(posedge clk); while (!in_ready);
		if (cmd) n_restarts++;
		else n_steps++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic setup(logic mode, logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d, logic [31:0] t0, logic [31:0] t1, logic [31:0] u0);
		write_reg(REG_MODE, {31'(0), mode});
		write_reg(REG_COEF_A, a);
		write_reg(REG_COEF_B, b);
		write_reg(REG_COEF_C, c);
		write_reg(REG_COEF_D, d);
		write_reg(REG_INIT_TEMP, t0);
		write_reg(REG_INIT_OLDER, t1);
		write_reg(REG_INIT_CONTROL, u0);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [31:0] pick_coef(int style);
		logic [31:0] ext [5] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff};
		case (style)
			0: return $urandom_range(0, 131072) - 65536;
			1: return $urandom;
			default: return ext[$urandom_range(0, 4)];
		endcase
	endfunction

	function automatic logic [31:0] pick_control();
		logic [31:0] ext [4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
		case ($urandom_range(0, 9))
			0: return ext[$urandom_range(0, 3)];
			1, 2, 3, 4: return $urandom_range(0, 32'h00080000) - 32'h00040000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int style;
		logic [31:0] ctl_dir [6] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
			32'h1, 32'h00010000};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = 1'b0;
		control = '0;
		hold_req = 1'b0;
		idle_cycles = 0;
		n_steps = 0;
		n_restarts = 0;
		n_settings = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		transfer(1'b0, 32'h00010000);
		transfer(1'b1, 32'h0);
		drain();
		setup(1'b0, 32'h00008000, 32'h00010000, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000,
			32'h0);
		transfer(1'b1, 32'h0);
		foreach (ctl_dir[i]) transfer(1'b0, ctl_dir[i]);
		drain();
		setup(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h7fffffff);
		transfer(1'b1, 32'hffffffff);
		foreach (ctl_dir[i]) transfer(1'b0, ctl_dir[i]);
		transfer(1'b1, 32'h0);
		transfer(1'b0, 32'h0);
		drain();
		setup(1'b1, 32'h0000c000, 32'hffff8000, 32'h00020000, 32'h80000000, 32'h00100000,
			32'hfff00000, 32'h80000000);
		transfer(1'b1, 32'h0);
		foreach (ctl_dir[i]) transfer(1'b0, ctl_dir[i]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			style = p % 3;
			setup(p[0], pick_coef(style), pick_coef(style), pick_coef(style), pick_coef(style),
				pick_coef(style), pick_coef(style), pick_coef(style));
			if (p == 4) hold_req = 1'b1;
			for (int i = 0; i < PER_PHASE; i++)
				transfer($urandom_range(0, 9) == 0, pick_control());
			drain();
		end
		setup(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		transfer(1'b0, $urandom);
		drain();

		$display("Covered %0d steps and %0d restarts under %0d register settings;",
			n_steps, n_restarts, n_settings);
		$display("%0d results checked, %0d of them clipped.", results, clipped);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
